@@ design/bpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared widths, codes, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_PAGES_DEF  = 1024;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int ADDR_W   = 48;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 64;

  // Request opcodes.
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  // Configuration register indexes (byte address bit 3).
  localparam logic REG_ALLOWED_PAGES = 1'b0;
  localparam logic REG_REGION_BASE   = 1'b1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam logic [CNT_W-1:0] ALLOWED_PAGES_RST = 11'd1024;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic [CNT_W-1:0]    pages_in_use;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACQ_SCAN,
    ST_ACQ_MUL,
    ST_REL_SUB,
    ST_REL_DIV,
    ST_REL_RD,
    ST_REL_CHK,
    ST_FIN
  } alloc_state_t;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic scan;
    logic mul;
    logic rel_sub;
    logic div_step;
    logic rel_chk;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_op;
    logic clear_last;
    logic scan_found;
    logic scan_fail;
    logic rel_bad;
  } dp_status_t;

endpackage

@@ design/bitmap_page_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator unit
// Acquire: first-fit scan of k bitmap words (1 to 16 at the default size), then
// the page address multiply, which is skipped when no page is free. Release:
// range check, page division, bitmap read and check; an out-of-range address
// skips to the result. Next request is taken the cycle after the result is loaded.
// Reset: a bitmap clearing pass runs before the first request is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CNT_W-1:0]  allowed_pages;
  logic [ADDR_W-1:0] region_base;
  ctrl_cmd_t         cmd;
  dp_status_t        st;

  bpa_cfg_regs u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .allowed_pages_r (allowed_pages),
    .region_base_r   (region_base)
  );

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_data       (in_data),
    .allowed_pages (allowed_pages),
    .region_base   (region_base),
    .cmd           (cmd),
    .st            (st),
    .out_data      (out_data)
  );

endmodule

@@ design/bpa_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator configuration registers
// APB-style register file holding the allowed page count and region base.
// ----------------------------------------------------------------------------
module bpa_cfg_regs
  import bpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CNT_W-1:0]      allowed_pages_r,
  output logic [ADDR_W-1:0]     region_base_r
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // Registers sit on 8-byte boundaries; the low address bits are not decoded.
  assign reg_idx = paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_pages_r <= ALLOWED_PAGES_RST;
      region_base_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ALLOWED_PAGES: allowed_pages_r <= pwdata[CNT_W-1:0];
        REG_REGION_BASE:   region_base_r   <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ALLOWED_PAGES: prdata = CFG_DATA_W'(allowed_pages_r);
      REG_REGION_BASE:   prdata = CFG_DATA_W'(region_base_r);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ design/bpa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences the clearing pass, acquire scan and release check, and owns the
// request and result handshakes.
// ----------------------------------------------------------------------------
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  alloc_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (st.in_op == OP_RELEASE) ? ST_REL_SUB : ST_ACQ_SCAN;
        end
      end
      ST_ACQ_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_found) begin
          state_nxt = ST_ACQ_MUL;
        end else if (st.scan_fail) begin
          state_nxt = ST_FIN;
        end
      end
      ST_ACQ_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_REL_SUB: begin
        cmd.rel_sub = 1'b1;
        state_nxt   = st.rel_bad ? ST_FIN : ST_REL_DIV;
      end
      ST_REL_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_REL_RD;
      end
      ST_REL_RD: begin
        state_nxt = ST_REL_CHK;
      end
      ST_REL_CHK: begin
        cmd.rel_chk = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // Hold the finished result until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/bpa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Bitmap memory, used-page counter, first-fit word scan, address-to-page
// conversion and result register.
// ----------------------------------------------------------------------------
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic [CNT_W-1:0]  allowed_pages,
  input  logic [ADDR_W-1:0] region_base,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        st,
  output out_item_t         out_data
);

  localparam int NWORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PW     = WW + 6;
  localparam int LW     = (PW + 1 > CNT_W) ? PW + 1 : CNT_W;
  localparam longint unsigned SPAN_BYTES = longint'(MAX_PAGES) * longint'(PAGE_BYTES);
  localparam int OW     = $clog2(SPAN_BYTES);
  localparam int PBW    = $clog2(PAGE_BYTES + 1);
  localparam int PRW    = PW + PBW;
  // Page number by reciprocal multiplication; exact for every offset below 2**OW.
  localparam int RS     = OW + PBW;
  localparam longint unsigned RM =
    ((longint'(1) << RS) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES);
  localparam int RMW    = $clog2(RM + 1);
  localparam int QW     = OW + RMW;

  logic [WORD_W-1:0] bitmap_mem [NWORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic [WW-1:0]     rd_addr;
  logic              mem_we;
  logic [WW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;

  in_item_t            req_r;
  logic [CNT_W-1:0]    used_r;
  logic [WW-1:0]       clr_w_r;
  logic [WW-1:0]       chk_w_r;
  logic [PW-1:0]       page_r;
  logic [OW-1:0]       rem_r;
  logic [PRW-1:0]      prod_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                res_acq_ok_r;
  out_item_t           out_r;

  // Acquire scan
  logic [LW-1:0]     limit_l;
  logic [LW-1:0]     allowed_l;
  logic [LW-1:0]     next_base;
  logic              full;
  logic              partial;
  logic              last_word;
  logic [WORD_W-1:0] limit_mask;
  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] lsb;
  logic [5:0]        bit_idx;
  logic              scan_found;

  // Release
  logic [ADDR_W:0] diff;
  logic            page_set;
  logic            rel_ok;

  // --------------------------------------------------------------------------
  // Acquire: one bitmap word per cycle, pages at or above the limit read as used.
  // --------------------------------------------------------------------------
  assign allowed_l = LW'(allowed_pages);
  assign limit_l   = (allowed_l > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : allowed_l;
  assign full      = LW'(used_r) >= limit_l;
  assign next_base = (LW'(chk_w_r) + LW'(1)) << 6;
  assign partial   = limit_l < next_base;
  assign last_word = (limit_l <= next_base) || (chk_w_r == WW'(NWORDS - 1));
  assign limit_mask = partial ? ~((WORD_W'(1) << limit_l[5:0]) - WORD_W'(1)) : '0;
  assign free_bits  = ~(rd_data_r | limit_mask);
  assign lsb        = free_bits & (~free_bits + WORD_W'(1));
  assign scan_found = !full && (free_bits != '0);

  always_comb begin
    bit_idx = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (lsb[b]) begin
        bit_idx = bit_idx | 6'(b);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Release: offset check, then division by the page size as a reciprocal multiply.
  // --------------------------------------------------------------------------
  assign diff     = {1'b0, req_r.release_address} - {1'b0, region_base};
  assign page_set = rd_data_r[page_r[5:0]];
  assign rel_ok   = page_set && (used_r != '0);

  assign st.in_op      = in_data.opcode;
  assign st.clear_last = clr_w_r == WW'(NWORDS - 1);
  assign st.scan_found = scan_found;
  assign st.scan_fail  = !scan_found && (full || last_word);
  assign st.rel_bad    = diff[ADDR_W] || (diff[ADDR_W-1:0] >= ADDR_W'(SPAN_BYTES));

  // --------------------------------------------------------------------------
  // Bitmap memory
  // --------------------------------------------------------------------------
  always_comb begin
    if (cmd.accept) begin
      rd_addr = '0;
    end else if (cmd.scan) begin
      rd_addr = chk_w_r + WW'(1);
    end else begin
      rd_addr = page_r[PW-1:6];
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_w_r;
    mem_wd = '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd.scan && scan_found) begin
      mem_we = 1'b1;
      mem_wa = chk_w_r;
      mem_wd = rd_data_r | lsb;
    end else if (cmd.rel_chk && rel_ok) begin
      mem_we = 1'b1;
      mem_wa = page_r[PW-1:6];
      mem_wd = rd_data_r & ~(WORD_W'(1) << page_r[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= bitmap_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Control counters
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      clr_w_r <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clr_w_r <= clr_w_r + WW'(1);
      end
      if (cmd.scan && scan_found) begin
        used_r <= used_r + CNT_W'(1);
      end else if (cmd.rel_chk && rel_ok) begin
        used_r <= used_r - CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request, scan and page registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r        <= in_data;
      chk_w_r      <= '0;
      res_status_r <= STATUS_OK;
      res_acq_ok_r <= 1'b0;
    end
    if (cmd.scan) begin
      if (scan_found) begin
        page_r       <= {chk_w_r, bit_idx};
        res_acq_ok_r <= 1'b1;
      end else if (full || last_word) begin
        res_status_r <= STATUS_NO_FREE;
      end else begin
        chk_w_r <= chk_w_r + WW'(1);
      end
    end
    if (cmd.mul) begin
      prod_r <= PRW'(page_r) * PRW'(PAGE_BYTES);
    end
    if (cmd.rel_sub) begin
      if (st.rel_bad) begin
        res_status_r <= STATUS_INVALID;
      end
      rem_r <= diff[OW-1:0];
    end
    if (cmd.div_step) begin
      page_r <= PW'((QW'(rem_r) * QW'(RM)) >> RS);
    end
    if (cmd.rel_chk && !rel_ok) begin
      res_status_r <= STATUS_INVALID;
    end
    if (cmd.load_out) begin
      out_r.status       <= res_status_r;
      out_r.page_address <= res_acq_ok_r ? (region_base + ADDR_W'(prod_r)) : '0;
      out_r.pages_in_use <= used_r;
    end
  end

  assign out_data = out_r;

endmodule
